// ===== rtl/atf_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt angle filter.
package atf_pkg;

    localparam int SQRT_STEPS   = 24;   // one root bit per cell
    localparam int CORDIC_STEPS = 16;   // micro-rotations, 8..24
    localparam int ATAN_LEN     = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_FEED,
        ST_WAIT,
        ST_DONE
    } atf_state_t;

    typedef enum logic [1:0] {
        TAG_ROLL    = 2'd0,
        TAG_PITCH   = 2'd1,
        TAG_INCLINE = 2'd2
    } angle_tag_t;

    typedef enum logic [1:0] {
        REG_FILTER_SHIFT = 2'd0
    } reg_addr_t;

    typedef struct packed {
        logic              valid;
        angle_tag_t        tag;
        logic [47:0]       radicand;
        logic [25:0]       rem;
        logic [23:0]       root;
    } sqrt_stage_t;

    typedef struct packed {
        logic              valid;
        angle_tag_t        tag;
        logic              zero;
        logic signed [27:0] x;
        logic signed [27:0] y;
        logic signed [31:0] z;
    } cordic_stage_t;

    // atan(2^-i) in hundredths of a degree, 16 fraction bits
    function automatic logic signed [31:0] atan_angle(input logic [4:0] idx);
        logic signed [31:0] a;
        unique case (idx)
            5'd0:  a = 32'sd294912000;
            5'd1:  a = 32'sd174096719;
            5'd2:  a = 32'sd91987925;
            5'd3:  a = 32'sd46694507;
            5'd4:  a = 32'sd23437865;
            5'd5:  a = 32'sd11730358;
            5'd6:  a = 32'sd5866610;
            5'd7:  a = 32'sd2933484;
            5'd8:  a = 32'sd1466764;
            5'd9:  a = 32'sd733385;
            5'd10: a = 32'sd366693;
            5'd11: a = 32'sd183346;
            5'd12: a = 32'sd91673;
            5'd13: a = 32'sd45837;
            5'd14: a = 32'sd22918;
            5'd15: a = 32'sd11459;
            5'd16: a = 32'sd5730;
            5'd17: a = 32'sd2865;
            5'd18: a = 32'sd1432;
            5'd19: a = 32'sd716;
            5'd20: a = 32'sd358;
            5'd21: a = 32'sd179;
            5'd22: a = 32'sd90;
            5'd23: a = 32'sd45;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/accel_tilt_angle_filter.sv =====
// Top level: sample latch, low-pass filter, sqrt and CORDIC chains, output word.
// Structure: an accepted word is squared axis by axis on one shared multiplier, its
//   three radicands are fed in turn into 24 sqrt cells, then 1 entry stage,
//   16 CORDIC cells and a capture register lead to the output register.
// The sequencer takes one word at a time and stalls its input while busy; it
//   takes a new word once the previous result has moved to the output register.
// Reset: filter_shift returns to 1, latched sample and filter state clear to 0.
module accel_tilt_angle_filter
    import atf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic               fresh,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic [14:0]        incline_angle
);

    // ---------------- configuration ----------------
    logic [2:0] shift_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FILTER_SHIFT) ? {29'd0, shift_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 3'd1;
        end
        else if (psel && penable && pwrite && paddr == REG_FILTER_SHIFT)
        begin
            shift_reg <= pwdata[2:0];
        end
    end

    // ---------------- sequencer ----------------
    atf_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       out_load;
    logic       last_done;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 2'd0;
                if (accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                // one axis squared per cycle
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_FEED;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_FEED:
            begin
                // push roll, pitch, incline radicands back to back
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_WAIT:
            begin
                if (last_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- sample latch and low-pass filter ----------------
    logic signed [15:0] sample_reg [3];
    logic signed [23:0] filt_reg   [3];
    logic signed [15:0] sample_in  [3];
    logic signed [15:0] sample_use [3];
    logic signed [23:0] filt_next  [3];

    assign sample_in[0] = accel_x;
    assign sample_in[1] = accel_y;
    assign sample_in[2] = accel_z;

    always_comb
    begin
        logic signed [24:0] diff;
        for (int i = 0; i < 3; i++)
        begin
            sample_use[i] = fresh ? sample_in[i] : sample_reg[i];
            diff = 25'(signed'({sample_use[i], 8'd0})) - 25'(filt_reg[i]);
            filt_next[i] = 24'(25'(filt_reg[i]) + (diff >>> shift_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sample_reg[i] <= 16'sd0;
                filt_reg[i]   <= 24'sd0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sample_reg[i] <= sample_use[i];
                filt_reg[i]   <= filt_next[i];
            end
        end
    end

    // ---------------- squares on one shared multiplier ----------------
    logic [46:0]        sq_reg [3];
    logic signed [23:0] sq_op;
    logic signed [47:0] sq_prod;

    assign sq_op   = filt_reg[cnt_reg];
    assign sq_prod = sq_op * sq_op;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SQUARE)
        begin
            sq_reg[cnt_reg] <= sq_prod[46:0];
        end
    end

    // ---------------- square root chain ----------------
    sqrt_stage_t sqrt_chain [SQRT_STEPS + 1];

    always_comb
    begin
        sqrt_chain[0] = '0;
        sqrt_chain[0].valid = (state_reg == ST_FEED);
        sqrt_chain[0].tag   = angle_tag_t'(cnt_reg);
        unique case (cnt_reg)
            TAG_ROLL:  sqrt_chain[0].radicand = 48'(sq_reg[0]) + 48'(sq_reg[2]);
            TAG_PITCH: sqrt_chain[0].radicand = 48'(sq_reg[1]) + 48'(sq_reg[2]);
            default:   sqrt_chain[0].radicand = 48'(sq_reg[0]) + 48'(sq_reg[1]);
        endcase
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        atf_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bit_pos   (5'(SQRT_STEPS - 1 - j)),
            .stage_in  (sqrt_chain[j]),
            .stage_out (sqrt_chain[j + 1])
        );
    end

    // ---------------- CORDIC entry: operand pick and quadrant turn ----------------
    cordic_stage_t cordic_chain [CORDIC_STEPS + 1];
    cordic_stage_t entry_reg, entry_next;
    sqrt_stage_t   root_w;

    assign root_w = sqrt_chain[SQRT_STEPS];

    always_comb
    begin
        logic signed [27:0] a;
        logic signed [27:0] b;
        logic signed [27:0] r;
        r = 28'(root_w.root);
        unique case (root_w.tag)
            TAG_ROLL:
            begin
                a = 28'(filt_reg[1]);
                b = r;
            end
            TAG_PITCH:
            begin
                a = 28'(filt_reg[0]);
                b = r;
            end
            default:
            begin
                a = r;
                b = 28'(filt_reg[2]);
            end
        endcase
        entry_next.valid = root_w.valid;
        entry_next.tag   = root_w.tag;
        entry_next.zero  = (a == 28'sd0) && (b == 28'sd0);
        if (b[27])
        begin
            if (!a[27])
            begin
                entry_next.x = a;
                entry_next.y = -b;
                entry_next.z = atan_angle(5'd0) <<< 1;
            end
            else
            begin
                entry_next.x = -a;
                entry_next.y = b;
                entry_next.z = -(atan_angle(5'd0) <<< 1);
            end
        end
        else
        begin
            entry_next.x = b;
            entry_next.y = a;
            entry_next.z = 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign cordic_chain[0] = entry_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        atf_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (5'(k)),
            .angle     (atan_angle(5'(k))),
            .stage_in  (cordic_chain[k]),
            .stage_out (cordic_chain[k + 1])
        );
    end

    // ---------------- round, clamp, capture ----------------
    cordic_stage_t      fin;
    logic signed [32:0] rounded;
    logic signed [14:0] angle_clamped;

    assign fin       = cordic_chain[CORDIC_STEPS];
    assign last_done = fin.valid && fin.tag == TAG_INCLINE;

    always_comb
    begin
        rounded = (33'(fin.z) + 33'sd32768) >>> 16;
        if (fin.zero)
        begin
            angle_clamped = 15'sd0;
        end
        else if (fin.tag == TAG_INCLINE)
        begin
            if (rounded < 33'sd0)
                angle_clamped = 15'sd0;
            else if (rounded > 33'sd18000)
                angle_clamped = 15'(18000);
            else
                angle_clamped = rounded[14:0];
        end
        else
        begin
            if (rounded < -33'sd9000)
                angle_clamped = -15'sd9000;
            else if (rounded > 33'sd9000)
                angle_clamped = 15'sd9000;
            else
                angle_clamped = rounded[14:0];
        end
    end

    logic [14:0] roll_st_reg, pitch_st_reg, incl_st_reg;

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            unique case (fin.tag)
                TAG_ROLL:  roll_st_reg  <= angle_clamped;
                TAG_PITCH: pitch_st_reg <= angle_clamped;
                default:   incl_st_reg  <= angle_clamped;
            endcase
        end
    end

    // ---------------- output word ----------------
    logic        out_valid_reg;
    logic [14:0] roll_out_reg, pitch_out_reg, incl_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            roll_out_reg  <= roll_st_reg;
            pitch_out_reg <= pitch_st_reg;
            incl_out_reg  <= incl_st_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign roll_angle    = roll_out_reg;
    assign pitch_angle   = pitch_out_reg;
    assign incline_angle = incl_out_reg;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SQUARE)
        else $error("accepted word did not start squaring");

    a_cordic_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> state_reg == ST_WAIT)
        else $error("CORDIC result outside wait state");

    a_done_after_incline: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DONE) |-> $past(last_done))
        else $error("done without incline result");

    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");

endmodule

// ===== rtl/atf_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module atf_sqrt_cell
    import atf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  bit_pos,
    input  sqrt_stage_t stage_in,
    output sqrt_stage_t stage_out
);

    sqrt_stage_t stage_reg;
    sqrt_stage_t stage_next;
    logic [47:0] shifted;
    logic [27:0] rem_sh;
    logic [27:0] trial;

    always_comb
    begin
        // bring down the next two radicand bits
        shifted = stage_in.radicand >> {bit_pos, 1'b0};
        rem_sh  = {stage_in.rem, shifted[1:0]};
        trial   = {2'b00, stage_in.root, 2'b01};
        stage_next = stage_in;
        if (rem_sh >= trial)
        begin
            stage_next.rem  = 26'(rem_sh - trial);
            stage_next.root = {stage_in.root[22:0], 1'b1};
        end
        else
        begin
            stage_next.rem  = rem_sh[25:0];
            stage_next.root = {stage_in.root[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/atf_cordic_cell.sv =====
// One micro-rotation cell of the vectoring CORDIC chain.
module atf_cordic_cell
    import atf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         shift,
    input  logic signed [31:0] angle,
    input  cordic_stage_t      stage_in,
    output cordic_stage_t      stage_out
);

    cordic_stage_t stage_reg;
    cordic_stage_t stage_next;
    logic signed [27:0] dx;
    logic signed [27:0] dy;

    always_comb
    begin
        dx = stage_in.y >>> shift;
        dy = stage_in.x >>> shift;
        stage_next = stage_in;
        if (!stage_in.y[27])
        begin
            stage_next.x = stage_in.x + dx;
            stage_next.y = stage_in.y - dy;
            stage_next.z = stage_in.z + angle;
        end
        else
        begin
            stage_next.x = stage_in.x - dx;
            stage_next.y = stage_in.y + dy;
            stage_next.z = stage_in.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== tb/accel_tilt_angle_filter_test.sv =====
// Self-checking testbench for the accelerometer tilt angle filter.
module accel_tilt_angle_filter_test;
    import atf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_WORDS = 1800;
    localparam int  LATENCY_WAIT = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               fresh;
    } sample_word_t;

    typedef struct {
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
        logic [14:0]        incline;
    } angle_word_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic fresh;
    logic out_valid, out_stall;
    logic signed [14:0] roll_angle, pitch_angle;
    logic [14:0] incline_angle;

    accel_tilt_angle_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .fresh(fresh),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .incline_angle(incline_angle)
    );

    // Predictor state: shadow of the block's register and filter
    logic [2:0]         shadow_shift;
    logic signed [15:0] held_sample [3];
    logic signed [23:0] smooth_axis [3];

    sample_word_t pending_words[$];
    angle_word_t  expected_angles[$];

    int  mismatch_count;
    longint cycle_count;
    bit  calm_phase;      // no idling near the end
    bit  hold_off_req;    // ask the monitor for a long stall
    int  hold_off_left;
    int  send_gap, recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Arithmetic shift that rounds toward minus infinity
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint a, longint b);
        longint x, y, z, t, dx, dy;
        x = b;
        y = a;
        z = 0;
        if (a == 0 && b == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 2 * longint'(atan_angle(5'd0));
            end
            else
            begin
                x = -y; y = t; z = -2 * longint'(atan_angle(5'd0));
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += longint'(atan_angle(5'(i)));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_angle(5'(i)));
            end
        end
        return floor_shift(z + 32768, 16);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Advance the filter by one word and return the three tilt angles
    function automatic angle_word_t predict_tilt(sample_word_t w);
        longint f [3];
        longint sq [3];
        longint diff;
        angle_word_t r;
        if (w.fresh)
        begin
            held_sample[0] = w.ax;
            held_sample[1] = w.ay;
            held_sample[2] = w.az;
        end
        for (int i = 0; i < 3; i++)
        begin
            diff = longint'(held_sample[i]) * 256 - longint'(smooth_axis[i]);
            smooth_axis[i] = 24'(longint'(smooth_axis[i]) + floor_shift(diff, shadow_shift));
            f[i] = smooth_axis[i];
            sq[i] = f[i] * f[i];
        end
        r.roll    = 15'(clip(vector_angle(f[1], floor_sqrt(sq[0] + sq[2])), -9000, 9000));
        r.pitch   = 15'(clip(vector_angle(f[0], floor_sqrt(sq[1] + sq[2])), -9000, 9000));
        r.incline = 15'(clip(vector_angle(floor_sqrt(sq[0] + sq[1]), f[2]), 0, 18000));
        return r;
    endfunction

    // Driver: offer queued words, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
            accel_x  <= '0;
            accel_y  <= '0;
            accel_z  <= '0;
            fresh    <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_angles.push_back(predict_tilt(pending_words.pop_front()));
            end
            if (in_valid && in_stall)
                ;   // hold the stalled word
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !(in_valid && pending_words.size() == 0))
            begin
                if (!calm_phase && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(1, 13) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    accel_x  <= pending_words[0].ax;
                    accel_y  <= pending_words[0].ay;
                    accel_z  <= pending_words[0].az;
                    fresh    <= pending_words[0].fresh;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: stall at random, check each accepted angle word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            recv_gap      <= 0;
            hold_off_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected angle word roll=%0d pitch=%0d incline=%0d",
                                 roll_angle, pitch_angle, incline_angle);
                end
                else
                begin
                    angle_word_t e;
                    e = expected_angles.pop_front();
                    if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
                        e.incline !== incline_angle)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("angle mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.roll, e.pitch, e.incline,
                                     roll_angle, pitch_angle, incline_angle);
                    end
                end
            end
            // A long hold-off lets the block back up into its input
            if (hold_off_req && hold_off_left == 0 && !out_stall)
            begin
                hold_off_left <= 600;
                out_stall     <= 1'b1;
            end
            else if (hold_off_left > 1)
                hold_off_left <= hold_off_left - 1;
            else if (hold_off_left == 1)
            begin
                hold_off_left <= 0;
                out_stall     <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= (recv_gap > 1);
            end
            else if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                recv_gap  <= $urandom_range(1, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_shift(input logic [2:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_FILTER_SHIFT) << 2 >> 2;
        pwdata  <= {29'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_shift = value;
    endtask

    task automatic drain_all();
        while (pending_words.size() > 0 || in_valid || expected_angles.size() > 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    function automatic void queue_word(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                       logic f);
        sample_word_t w;
        w.ax = x; w.ay = y; w.az = z; w.fresh = f;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0:       queue_word(16'h8000 + 16'($urandom_range(0, 3)),
                                    16'($urandom), 16'($urandom), 1'b1);
                1:       queue_word(16'($urandom_range(0, 8)) - 16'd4,
                                    16'($urandom_range(0, 8)) - 16'd4,
                                    16'($urandom_range(0, 8)) - 16'd4, 1'b1);
                2:       queue_word(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
                default: queue_word(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
            endcase
        end
    endfunction

    initial
    begin
        logic [2:0] shift_plan [6];
        shift_plan = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd0, 3'd5};
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatch_count = 0;
        cycle_count = 0;
        calm_phase = 1'b0;
        hold_off_req = 1'b0;
        shadow_shift = 3'd1;
        for (int i = 0; i < 3; i++)
        begin
            held_sample[i] = '0;
            smooth_axis[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stale word before any fresh one, extremes, zero vectors,
        // negative z (quadrant turn), then a rebound to positive
        queue_word(16'sd1234, -16'sd77, 16'sd9, 1'b0);
        queue_word(16'sd0, 16'sd0, 16'sd0, 1'b1);
        queue_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        queue_word(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        queue_word(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        queue_word(16'sd0, 16'sd0, -16'sd4096, 1'b1);
        queue_word(16'sd0, 16'sd0, 16'sd4096, 1'b1);
        queue_word(16'sd4096, 16'sd0, 16'sd0, 1'b1);
        queue_word(-16'sd4096, 16'sd0, 16'sd0, 1'b1);
        queue_word(16'sd0, -16'sd4096, 16'sd0, 1'b1);
        queue_word(16'sd1, -16'sd1, 16'sd1, 1'b1);
        queue_word(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0);
        queue_word(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b1);
        drain_all();

        // Several filter settings, extremes included; pause the sender and
        // drain between them before each register write
        for (int p = 0; p < 6; p++)
        begin
            write_shift(shift_plan[p]);
            queue_word(16'sd0, 16'sd0, 16'sd0, 1'b1);
            queue_word(16'sh7FFF, 16'sh8000, -16'sd1, 1'b1);
            if (p == 1)
            begin
                queue_random(40);
                hold_off_req = 1'b1;
                // keep asking until the monitor has started the hold-off
                wait (hold_off_left != 0);
                hold_off_req = 1'b0;
            end
            queue_random(RANDOM_WORDS / 6 - 40 * (p == 1));
            if (p == 5)
                calm_phase = 1'b1;
            drain_all();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
